// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the scan curvature marker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define SCOM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scom checker: property failed");

// Next-cycle implication, checked at each rising edge outside reset.
`define SCOM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scom checker: property failed");

`endif

// ===== hdl/scom_pkg.sv =====
// Shared widths, register map, reset values and item types of the scan curvature marker.
package scom_pkg;

    // Field widths of the point and result items.
    localparam int RANGE_W   = 18;
    localparam int COL_W     = 11;
    localparam int CURV_W    = 44;
    localparam int GAP_W     = 18;
    localparam int RATIO_W   = 16;

    // Default half window: neighbors taken on each side of a point.
    localparam int HALF_WINDOW_DEF = 5;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_OCC_GAP   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COL_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PARALLAX  = 2'd2;

    // Register reset values.
    localparam logic [GAP_W-1:0]   OCC_GAP_RST   = 18'd300;
    localparam logic [COL_W-1:0]   COL_LIMIT_RST = 11'd10;
    localparam logic [RATIO_W-1:0] PARALLAX_RST  = 16'd1311;

    // One incoming lidar point.
    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [COL_W-1:0]   column;
        logic               end_of_scan;
    } point_t;

    // One marked point leaving the block.
    typedef struct packed {
        logic [RANGE_W-1:0] point_range_mm;
        logic [COL_W-1:0]   point_column;
        logic [CURV_W-1:0]  curvature;
        logic               curvature_valid;
        logic               excluded;
        logic               last_point;
    } result_t;

    // Point handed from the window to the curvature pipeline.
    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [COL_W-1:0]   column;
        logic               excluded;
        logic               curv_valid;
        logic               last_point;
    } emit_t;

endpackage

// ===== hdl/scom_curv_pipe.sv =====
// Three-stage curvature pipeline: neighbor sum, absolute difference, square.
module scom_curv_pipe #(
    parameter int HALF_WINDOW = scom_pkg::HALF_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          emit_valid,
    output logic                          emit_ready,
    input  scom_pkg::emit_t               emit,
    input  logic [scom_pkg::RANGE_W-1:0]  nbr [2*HALF_WINDOW],
    output logic                          result_valid,
    input  logic                          result_ready,
    output scom_pkg::result_t             result
);

    localparam int NBR   = 2 * HALF_WINDOW;
    localparam int SUM_W = scom_pkg::RANGE_W + $clog2(NBR);
    localparam int SQ_W  = 2 * SUM_W;
    localparam logic [SUM_W-1:0] NBR_CNT = SUM_W'(NBR);

    logic                 b_vld_reg;
    scom_pkg::emit_t      b_emit_reg;
    logic [SUM_W-1:0]     b_sum_reg;
    logic                 c_vld_reg;
    scom_pkg::emit_t      c_emit_reg;
    logic [SUM_W-1:0]     c_diff_reg;
    logic                 d_vld_reg;
    scom_pkg::result_t    d_res_reg;

    logic                 b_rdy;
    logic                 c_rdy;
    logic                 d_rdy;
    logic [SUM_W-1:0]     nbr_sum;
    logic [SUM_W-1:0]     ctr_scaled;
    logic [SUM_W-1:0]     diff;
    logic [SQ_W-1:0]      sq;

    // Each stage loads when it is empty or its content moves on.
    assign d_rdy      = !d_vld_reg || result_ready;
    assign c_rdy      = !c_vld_reg || d_rdy;
    assign b_rdy      = !b_vld_reg || c_rdy;
    assign emit_ready = b_rdy;

    // Sum of the neighbor ranges.
    always_comb
    begin
        nbr_sum = '0;
        for (int i = 0; i < NBR; i++)
        begin
            nbr_sum = nbr_sum + SUM_W'(nbr[i]);
        end
    end

    // Distance between the neighbor sum and the scaled center range.
    assign ctr_scaled = SUM_W'(b_emit_reg.range_mm) * NBR_CNT;
    assign diff = (b_sum_reg >= ctr_scaled) ? (b_sum_reg - ctr_scaled)
                                            : (ctr_scaled - b_sum_reg);

    // Square of the difference.
    assign sq = SQ_W'(c_diff_reg) * SQ_W'(c_diff_reg);

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            if (b_rdy)
            begin
                b_vld_reg <= emit_valid;
            end
            if (c_rdy)
            begin
                c_vld_reg <= b_vld_reg;
            end
            if (d_rdy)
            begin
                d_vld_reg <= c_vld_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (b_rdy && emit_valid)
        begin
            b_emit_reg <= emit;
            b_sum_reg  <= nbr_sum;
        end
        if (c_rdy && b_vld_reg)
        begin
            c_emit_reg <= b_emit_reg;
            c_diff_reg <= diff;
        end
        if (d_rdy && c_vld_reg)
        begin
            d_res_reg.point_range_mm  <= c_emit_reg.range_mm;
            d_res_reg.point_column    <= c_emit_reg.column;
            d_res_reg.curvature       <= c_emit_reg.curv_valid ?
                                         scom_pkg::CURV_W'(sq) : '0;
            d_res_reg.curvature_valid <= c_emit_reg.curv_valid;
            d_res_reg.excluded        <= c_emit_reg.excluded;
            d_res_reg.last_point      <= c_emit_reg.last_point;
        end
    end

    assign result_valid = d_vld_reg;
    assign result       = d_res_reg;

endmodule

// ===== hdl/scan_curvature_occlusion_marker_core.sv =====
// Top level of the scan curvature and occlusion marker: window, marking tests and config port.
//
// Points of one scan enter in order, one per cycle while point_ready is high, and leave
// HALF_WINDOW+1 points later with their curvature, a curvature valid bit and an excluded
// bit. In steady state the block takes one item per cycle unless result_ready stalls it;
// a result passes through the sum, difference and square registers after the item that
// pushes its point to the center of the shift window. After an item with end_of_scan,
// point_ready stays low while the window shifts out the remaining points; this flush and
// result_ready set the rate. The occlusion and parallax tests run on the window as each
// item enters; the curvature goes through a sum, difference and square stage. The
// configuration registers sit at byte addresses 0, 4 and 8 and should be written only
// between scans.
module scan_curvature_occlusion_marker_core #(
    parameter int HALF_WINDOW = scom_pkg::HALF_WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scom_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [scom_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [scom_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              point_valid,
    output logic                              point_ready,
    input  scom_pkg::point_t                  point,
    output logic                              result_valid,
    input  logic                              result_ready,
    output scom_pkg::result_t                 result
);

    localparam int DEPTH  = 2 * HALF_WINDOW + 2;
    localparam int NBR    = 2 * HALF_WINDOW;
    localparam int PEND_W = $clog2(HALF_WINDOW + 1);
    localparam int PROD_W = scom_pkg::RATIO_W + scom_pkg::RANGE_W;
    localparam logic [PEND_W-1:0] PEND_FULL = PEND_W'(HALF_WINDOW);

    // Configuration registers.
    logic [scom_pkg::GAP_W-1:0]    occ_gap_reg;
    logic [scom_pkg::COL_W-1:0]    col_limit_reg;
    logic [scom_pkg::RATIO_W-1:0]  parallax_reg;
    logic                          cfg_wr;
    logic [scom_pkg::REG_IDX_W-1:0] reg_idx;

    // Shift window, newest point in slot 0.
    logic [scom_pkg::RANGE_W-1:0]  rng_win_reg [DEPTH];
    logic [scom_pkg::COL_W-1:0]    col_win_reg [DEPTH];
    logic [DEPTH-1:0]              exc_win_reg;
    logic [DEPTH-1:0]              real_win_reg;
    logic [scom_pkg::RANGE_W-1:0]  rng_sh [DEPTH];
    logic [scom_pkg::COL_W-1:0]    col_sh [DEPTH];
    logic [DEPTH-1:0]              exc_sh;
    logic [DEPTH-1:0]              real_sh;

    // Forward exclusions still owed, and the end-of-scan flush.
    logic [PEND_W-1:0]             pend_reg;
    logic [PEND_W-1:0]             pend_next;
    logic                          flush_reg;
    logic                          flush_next;
    logic [PEND_W-1:0]             flush_cnt_reg;
    logic [PEND_W-1:0]             flush_cnt_next;

    logic                          pipe_rdy;
    logic                          accept;
    logic                          flush_adv;
    logic                          flush_last;
    logic                          advance;

    // Marking tests.
    logic                          test_en;
    logic [scom_pkg::COL_W-1:0]    col_dist;
    logic                          col_near;
    logic [scom_pkg::RANGE_W:0]    near_plus_gap;
    logic [scom_pkg::RANGE_W:0]    new_plus_gap;
    logic                          occ_back;
    logic                          occ_fwd;
    logic                          back_mark;
    logic                          fwd_mark;
    logic [PROD_W-1:0]             par_lim;
    logic [scom_pkg::RANGE_W-1:0]  step_prev;
    logic [scom_pkg::RANGE_W-1:0]  step_next;
    logic                          par_mark;

    // Emission towards the curvature pipeline.
    logic                          emit_vld;
    scom_pkg::emit_t               emit;
    logic [scom_pkg::RANGE_W-1:0]  nbr [NBR];

    // Configuration port: writes complete in the access phase, reads are decoded.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[scom_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_gap_reg   <= scom_pkg::OCC_GAP_RST;
            col_limit_reg <= scom_pkg::COL_LIMIT_RST;
            parallax_reg  <= scom_pkg::PARALLAX_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                scom_pkg::REG_OCC_GAP:   occ_gap_reg   <= pwdata[scom_pkg::GAP_W-1:0];
                scom_pkg::REG_COL_LIMIT: col_limit_reg <= pwdata[scom_pkg::COL_W-1:0];
                scom_pkg::REG_PARALLAX:  parallax_reg  <= pwdata[scom_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            scom_pkg::REG_OCC_GAP:   prdata = scom_pkg::APB_DATA_W'(occ_gap_reg);
            scom_pkg::REG_COL_LIMIT: prdata = scom_pkg::APB_DATA_W'(col_limit_reg);
            scom_pkg::REG_PARALLAX:  prdata = scom_pkg::APB_DATA_W'(parallax_reg);
            default:                 prdata = '0;
        endcase
    end

    // The window moves on an accepted item or on a flush step, only when the pipeline
    // can take the point that reaches the center.
    assign point_ready = pipe_rdy && !flush_reg;
    assign accept      = point_valid && point_ready;
    assign flush_adv   = flush_reg && pipe_rdy;
    assign flush_last  = flush_adv && (flush_cnt_reg == PEND_FULL);
    assign advance     = accept || flush_adv;

    // Tests at the newest stored point, with the arriving item as its successor.
    assign test_en  = accept && real_win_reg[HALF_WINDOW];
    assign col_dist = (point.column >= col_win_reg[0]) ? (point.column - col_win_reg[0])
                                                       : (col_win_reg[0] - point.column);
    assign col_near = col_dist < col_limit_reg;

    assign near_plus_gap = {1'b0, rng_win_reg[0]} + {1'b0, occ_gap_reg};
    assign new_plus_gap  = {1'b0, point.range_mm} + {1'b0, occ_gap_reg};
    assign occ_back      = {1'b0, rng_win_reg[0]} > new_plus_gap;
    assign occ_fwd       = {1'b0, point.range_mm} > near_plus_gap;
    assign back_mark     = test_en && col_near && occ_back;
    assign fwd_mark      = test_en && col_near && !occ_back && occ_fwd;

    // Parallax: both neighbor steps exceed the ratio times the range.
    assign par_lim   = PROD_W'(parallax_reg) * PROD_W'(rng_win_reg[0]);
    assign step_prev = (rng_win_reg[1] >= rng_win_reg[0]) ? (rng_win_reg[1] - rng_win_reg[0])
                                                          : (rng_win_reg[0] - rng_win_reg[1]);
    assign step_next = (point.range_mm >= rng_win_reg[0]) ? (point.range_mm - rng_win_reg[0])
                                                          : (rng_win_reg[0] - point.range_mm);
    assign par_mark  = test_en
                    && ({step_prev, {scom_pkg::RATIO_W{1'b0}}} > par_lim)
                    && ({step_next, {scom_pkg::RATIO_W{1'b0}}} > par_lim);

    // Shifted window with this cycle's marks applied.
    always_comb
    begin
        rng_sh[0] = point.range_mm;
        col_sh[0] = point.column;
        for (int j = 1; j < DEPTH; j++)
        begin
            rng_sh[j] = rng_win_reg[j-1];
            col_sh[j] = col_win_reg[j-1];
        end
        exc_sh  = {exc_win_reg[DEPTH-2:0], accept && ((pend_reg != '0) || fwd_mark)};
        real_sh = {real_win_reg[DEPTH-2:0], accept};
        if (back_mark)
        begin
            for (int j = 1; j <= HALF_WINDOW + 1; j++)
            begin
                exc_sh[j] = 1'b1;
            end
        end
        if (par_mark)
        begin
            exc_sh[1] = 1'b1;
        end
    end

    // Point at the center slot and its neighbors.
    always_comb
    begin
        emit_vld        = advance && real_sh[HALF_WINDOW+1];
        emit.range_mm   = rng_sh[HALF_WINDOW+1];
        emit.column     = col_sh[HALF_WINDOW+1];
        emit.excluded   = exc_sh[HALF_WINDOW+1];
        emit.curv_valid = real_sh[1] && real_sh[DEPTH-1];
        emit.last_point = flush_last;
        for (int d = 1; d <= HALF_WINDOW; d++)
        begin
            nbr[d-1]             = rng_sh[HALF_WINDOW+1-d];
            nbr[HALF_WINDOW+d-1] = rng_sh[HALF_WINDOW+1+d];
        end
    end

    // Pending forward exclusions and flush sequencing.
    always_comb
    begin
        pend_next      = pend_reg;
        flush_next     = flush_reg;
        flush_cnt_next = flush_cnt_reg;
        if (accept)
        begin
            if (point.end_of_scan)
            begin
                pend_next      = '0;
                flush_next     = 1'b1;
                flush_cnt_next = '0;
            end
            else if (fwd_mark)
            begin
                pend_next = PEND_FULL;
            end
            else if (pend_reg != '0)
            begin
                pend_next = pend_reg - PEND_W'(1);
            end
        end
        if (flush_adv)
        begin
            if (flush_last)
            begin
                flush_next = 1'b0;
            end
            else
            begin
                flush_cnt_next = flush_cnt_reg + PEND_W'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_win_reg  <= '0;
            pend_reg      <= '0;
            flush_reg     <= 1'b0;
            flush_cnt_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                real_win_reg <= flush_last ? '0 : real_sh;
            end
            pend_reg      <= pend_next;
            flush_reg     <= flush_next;
            flush_cnt_reg <= flush_cnt_next;
        end
    end

    // Window payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rng_win_reg <= rng_sh;
            col_win_reg <= col_sh;
            exc_win_reg <= exc_sh;
        end
    end

    scom_curv_pipe #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_curv_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit_valid   (emit_vld),
        .emit_ready   (pipe_rdy),
        .emit         (emit),
        .nbr          (nbr),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== hdl/scom_checker.sv =====
// Port-level checker of the scan curvature marker and its bind to the top level.
`include "assert_macros.svh"

module scom_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              point_valid,
    input logic              point_ready,
    input scom_pkg::point_t  point,
    input logic              result_valid,
    input logic              result_ready,
    input scom_pkg::result_t result
);

    // A stalled result holds its value.
    `SCOM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

    // An end-of-scan item starts a flush, so no item is taken in the next cycle.
    `SCOM_ASSERT_NEXT(a_eos_flush, point_valid && point_ready && point.end_of_scan, !point_ready)

    // Without valid curvature the curvature field is zero.
    `SCOM_ASSERT_IMPL(a_curv_zero, result_valid && !result.curvature_valid, result.curvature == '0)

    // The last point of a scan has no neighbors after it, so no valid curvature.
    `SCOM_ASSERT_IMPL(a_last_no_curv, result_valid && result.last_point, !result.curvature_valid)

endmodule

bind scan_curvature_occlusion_marker_core scom_checker u_scom_checker (.*);

// ===== tb/tb_scan_curvature_occlusion_marker_core.sv =====
// Self-checking testbench for the scan curvature and occlusion marker core.
`timescale 1ns / 100ps

module tb_scan_curvature_occlusion_marker_core;

    localparam int HW          = scom_pkg::HALF_WINDOW_DEF;
    localparam int DEPTH       = 2 * HW + 2;
    localparam int MAX_PTS     = 32768;
    localparam int RANGE_MAX   = (1 << scom_pkg::RANGE_W) - 1;
    localparam int COL_MAX     = (1 << scom_pkg::COL_W) - 1;
    localparam int RATIO_MAX   = (1 << scom_pkg::RATIO_W) - 1;
    localparam int SETTLE_CYC  = HW + 8;
    localparam int CYCLE_LIMIT = 50000;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [scom_pkg::APB_ADDR_W-1:0] paddr;
    logic [scom_pkg::APB_DATA_W-1:0] pwdata;
    logic [scom_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            point_valid;
    logic                            point_ready;
    scom_pkg::point_t                point;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    scom_pkg::result_t               result;

    scan_curvature_occlusion_marker_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point        (point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Clock with a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow of the marking state: shift window (newest first), scan position and
    // the count of points still to be excluded after a near-to-far step.
    logic [scom_pkg::RANGE_W-1:0] win_range [DEPTH];
    logic [scom_pkg::COL_W-1:0]   win_col   [DEPTH];
    logic                         win_excl  [DEPTH];
    int unsigned                  scan_pos;
    int unsigned                  fwd_marks;

    // Shadow of the configuration registers.
    logic [scom_pkg::GAP_W-1:0]   occ_gap;
    logic [scom_pkg::COL_W-1:0]   col_limit;
    logic [scom_pkg::RATIO_W-1:0] ratio;

    // Marked points that the block still owes, oldest first.
    scom_pkg::result_t marked_due [$];
    int unsigned       mismatch_count;
    int unsigned       cycle_count;
    int                burst_left;

    // Clear the per-scan part of the shadow state.
    function automatic void clear_window();
        for (int s = 0; s < DEPTH; s++)
        begin
            win_range[s] = '0;
            win_col[s]   = '0;
            win_excl[s]  = 1'b0;
        end
        scan_pos  = 0;
        fwd_marks = 0;
    endfunction

    function automatic logic [63:0] abs_diff(logic [63:0] a, logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Squared difference between the ten neighbors and ten times the center.
    function automatic logic [scom_pkg::CURV_W-1:0] window_curvature(int s);
        logic [63:0] sum;
        logic [63:0] ctr;
        logic [63:0] diff;
        sum = '0;
        ctr = 64'(win_range[s]) * (2 * HW);
        for (int d = 1; d <= HW; d++)
            sum += 64'(win_range[s - d]) + 64'(win_range[s + d]);
        diff = abs_diff(sum, ctr);
        return scom_pkg::CURV_W'(diff * diff);
    endfunction

    // Queue the marked point held in window slot s.
    function automatic void queue_marked(int s, int unsigned idx, logic is_last);
        scom_pkg::result_t r;
        logic              curv_ok;
        curv_ok           = (idx >= s + HW) && (s >= HW);
        r.point_range_mm  = win_range[s];
        r.point_column    = win_col[s];
        r.curvature       = curv_ok ? window_curvature(s) : '0;
        r.curvature_valid = curv_ok;
        r.excluded        = win_excl[s];
        r.last_point      = is_last;
        marked_due.insert(marked_due.size(), r);
    endfunction

    // Advance the shadow window by one accepted point and queue what it releases.
    function automatic void predict_marked_points(scom_pkg::point_t p);
        int unsigned k;
        int          top;
        logic [63:0] r0;
        logic [63:0] r1;
        logic [63:0] r2;
        logic [63:0] cd;
        logic [63:0] lim;
        k = scan_pos;
        for (int s = DEPTH - 1; s > 0; s--)
        begin
            win_range[s] = win_range[s - 1];
            win_col[s]   = win_col[s - 1];
            win_excl[s]  = win_excl[s - 1];
        end
        win_range[0] = p.range_mm;
        win_col[0]   = p.column;
        win_excl[0]  = (fwd_marks > 0);
        if (fwd_marks > 0)
            fwd_marks--;

        // Occlusion and parallax tests on the point just behind the newest one.
        if (k >= HW + 1)
        begin
            r0 = 64'(win_range[0]);
            r1 = 64'(win_range[1]);
            r2 = 64'(win_range[2]);
            cd = abs_diff(64'(win_col[0]), 64'(win_col[1]));
            if (cd < 64'(col_limit))
            begin
                if (r1 > r0 + 64'(occ_gap))
                begin
                    for (int s = 1; s <= HW + 1; s++)
                        win_excl[s] = 1'b1;
                end
                else if (r0 > r1 + 64'(occ_gap))
                begin
                    win_excl[0] = 1'b1;
                    fwd_marks   = HW;
                end
            end
            lim = 64'(ratio) * r1;
            if ((abs_diff(r2, r1) << 16) > lim && (abs_diff(r0, r1) << 16) > lim)
                win_excl[1] = 1'b1;
        end

        // End of scan flushes the window, otherwise one point leaves once it is full.
        if (p.end_of_scan)
        begin
            top = (k < HW + 1) ? int'(k) : HW + 1;
            for (int s = top; s >= 0; s--)
                queue_marked(s, k, s == 0);
            clear_window();
        end
        else
        begin
            if (k >= HW + 1)
                queue_marked(HW + 1, k, 1'b0);
            if (scan_pos < MAX_PTS - 1)
                scan_pos++;
        end
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Compare every accepted result with the oldest marked point owed.
    always @(posedge clk)
    begin
        scom_pkg::result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_ready === 1'b1)
        begin
            if (marked_due.size() == 0)
            begin
                mismatch_count++;
                $error("result with no point owed: range %0d column %0d",
                       result.point_range_mm, result.point_column);
            end
            else
            begin
                want = marked_due.pop_front();
                compare_field("point_range_mm", want.point_range_mm, result.point_range_mm);
                compare_field("point_column", want.point_column, result.point_column);
                compare_field("curvature", want.curvature, result.curvature);
                compare_field("curvature_valid", want.curvature_valid,
                              result.curvature_valid);
                compare_field("excluded", want.excluded, result.excluded);
                compare_field("last_point", want.last_point, result.last_point);
            end
        end
    end

    // Receiver stalls: stretches always ready, stretches random, stretches mostly stalled.
    always @(posedge clk)
    begin
        int stall_mode;
        int stall_left;
        if (stall_left <= 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(1, 40);
        end
        stall_left--;
        case (stall_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= ($urandom_range(0, 1) == 1);
            default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_scan_curvature_occlusion_marker_core NOT OK");
            $finish;
        end
    end

    // Send one point, with random gaps between bursts, and predict its results.
    task automatic send_point(input scom_pkg::point_t p);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                point_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        point       <= p;
        point_valid <= 1'b1;
        do @(posedge clk); while (point_ready !== 1'b1);
        predict_marked_points(p);
    endtask

    // Stop sending until every owed result has come back.
    task automatic hold_until_drained();
        point_valid <= 1'b0;
        do @(posedge clk); while (marked_due.size() != 0);
    endtask

    // Drain, then let the flush and the curvature pipeline run dry.
    task automatic settle_block();
        hold_until_drained();
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // APB write of one register: setup cycle, then access cycle.
    task automatic write_reg(input logic [scom_pkg::REG_IDX_W-1:0] idx,
                             input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            scom_pkg::REG_OCC_GAP:   occ_gap   = value[scom_pkg::GAP_W-1:0];
            scom_pkg::REG_COL_LIMIT: col_limit = value[scom_pkg::COL_W-1:0];
            scom_pkg::REG_PARALLAX:  ratio     = value[scom_pkg::RATIO_W-1:0];
            default:                 ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_settings(input int unsigned gap_mm, input int unsigned col_lim,
                                  input int unsigned ratio_q16);
        settle_block();
        write_reg(scom_pkg::REG_OCC_GAP, gap_mm);
        write_reg(scom_pkg::REG_COL_LIMIT, col_lim);
        write_reg(scom_pkg::REG_PARALLAX, ratio_q16);
    endtask

    // One scan: mostly a smooth surface along consecutive columns, with edges,
    // spikes, column skips and some fully random points mixed in.
    task automatic random_scan(input int n);
        scom_pkg::point_t p;
        int               level;
        int               col;
        int               pick;
        level = $urandom_range(300, 200000);
        col   = $urandom_range(0, COL_MAX);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                p.range_mm = scom_pkg::RANGE_W'($urandom_range(0, RANGE_MAX));
                p.column   = scom_pkg::COL_W'($urandom_range(0, COL_MAX));
            end
            else
            begin
                col = ($urandom_range(0, 9) == 0) ? col + $urandom_range(2, 15) : col + 1;
                col = col % (COL_MAX + 1);
                if (pick < 14)
                    level = $urandom_range(0, RANGE_MAX);
                else
                    level = level + $urandom_range(0, 40) - 20;
                if (level < 0)
                    level = 0;
                if (level > RANGE_MAX)
                    level = RANGE_MAX;
                p.range_mm = scom_pkg::RANGE_W'(level);
                // A lone spike off the surface.
                if (pick >= 14 && pick < 19)
                    p.range_mm = scom_pkg::RANGE_W'(($urandom_range(0, 1) == 1)
                                 ? ((level + 3000 > RANGE_MAX) ? RANGE_MAX : level + 3000)
                                 : ((level < 3000) ? 0 : level - 3000));
                p.column = scom_pkg::COL_W'(col);
            end
            p.end_of_scan = (i == n - 1);
            send_point(p);
            if ($urandom_range(0, 49) == 0 && i != n - 1)
                hold_until_drained();
        end
    endtask

    // Random scans of mostly moderate length until the point budget is used.
    task automatic run_random_scans(input int budget);
        int n;
        while (budget > 0)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 30);
            random_scan(n);
            budget -= n;
        end
    endtask

    // Reset register values: back and forward occlusion, a parallax spike,
    // and range extremes at the end of the scan.
    task automatic test_default_scan();
        int               ranges [12] = '{4000, 4000, 4000, 4000, 4000, 4000,
                                          1000, 1000, 6000, 1000, RANGE_MAX, 0};
        scom_pkg::point_t p;
        for (int i = 0; i < 12; i++)
        begin
            p.range_mm    = scom_pkg::RANGE_W'(ranges[i]);
            p.column      = scom_pkg::COL_W'(i);
            p.end_of_scan = (i == 11);
            send_point(p);
        end
    endtask

    // Short scans, up to the longest one whose points all leave in the end-of-scan flush.
    task automatic test_short_scans();
        int               lengths [4] = '{1, 2, 6, 7};
        scom_pkg::point_t p;
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < lengths[j]; i++)
            begin
                p.range_mm    = scom_pkg::RANGE_W'((i == lengths[j] - 1) ? RANGE_MAX
                                                                         : 100 * i);
                p.column      = scom_pkg::COL_W'((i == lengths[j] - 1) ? COL_MAX : i);
                p.end_of_scan = (i == lengths[j] - 1);
                send_point(p);
            end
        end
    endtask

    // Register extremes: every test fires readily, then occlusion cannot fire and parallax takes its largest ratio.
    task automatic test_register_extremes();
        write_settings(0, COL_MAX, 0);
        run_random_scans(20);
        write_settings(RANGE_MAX, 0, RATIO_MAX);
        run_random_scans(20);
    endtask

    // Random realistic settings.
    task automatic test_random_settings();
        for (int j = 0; j < 3; j++)
        begin
            write_settings($urandom_range(50, 3000), $urandom_range(1, 40),
                           $urandom_range(300, 8000));
            run_random_scans(22);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        point_valid <= 1'b0;
        point       <= '0;
        occ_gap        = scom_pkg::OCC_GAP_RST;
        col_limit      = scom_pkg::COL_LIMIT_RST;
        ratio          = scom_pkg::PARALLAX_RST;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        clear_window();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_scan();
        test_short_scans();
        test_register_extremes();
        test_random_settings();
        settle_block();

        if (mismatch_count == 0 && marked_due.size() == 0)
            $display("tb_scan_curvature_occlusion_marker_core OK");
        else
            $display("tb_scan_curvature_occlusion_marker_core NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/scom_pkg.sv
hdl/scom_curv_pipe.sv
hdl/scan_curvature_occlusion_marker_core.sv
hdl/scom_checker.sv
tb/tb_scan_curvature_occlusion_marker_core.sv
